[hw/rtl/srp_pkg.sv]
// ----------------------------------------------------------------------------
// srp_pkg: shared types and constants of the SOCKS request parser
// Holds the result codes, the field kinds, the protocol byte values and the
// queue entry that passes from the front end to the back end.
// ----------------------------------------------------------------------------
package srp_pkg;

  typedef enum logic [2:0] {
    ACT_CONT   = 3'd0,
    ACT_GRANT4 = 3'd1,
    ACT_NOAUTH = 3'd2,
    ACT_READY  = 3'd3,
    ACT_CLOSE  = 3'd4,
    ACT_IGNORE = 3'd5
  } action_t;

  typedef enum logic [2:0] {
    FK_NONE   = 3'd0,
    FK_PORT_H = 3'd1,
    FK_PORT_L = 3'd2,
    FK_ADDR   = 3'd3,
    FK_NAME   = 3'd4,
    FK_USER   = 3'd5,
    FK_METHOD = 3'd6
  } field_kind_t;

  typedef enum logic [1:0] {
    DK_IPV4 = 2'd0,
    DK_NAME = 2'd1,
    DK_IPV6 = 2'd2
  } dest_kind_t;

  localparam logic [7:0] VER_SOCKS4   = 8'h04;
  localparam logic [7:0] VER_SOCKS5   = 8'h05;
  localparam logic [7:0] CMD_CONNECT  = 8'h01;
  localparam logic [7:0] ATYP_IPV4    = 8'h01;
  localparam logic [7:0] ATYP_NAME    = 8'h03;
  localparam logic [7:0] ATYP_IPV6    = 8'h04;
  localparam logic [7:0] BYTE_ZERO    = 8'h00;
  localparam logic [7:0] IPV4_BYTES   = 8'd4;
  localparam logic [7:0] IPV6_BYTES   = 8'd16;
  localparam logic [7:0] POS_SAT      = 8'hff;

  // byte as classified by the front end
  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_stream;
    logic       new_session;
    logic       is_zero;
    logic       is_one;
    logic       is_three;
    logic       is_four;
    logic       is_five;
  } q_item_t;

  typedef struct packed {
    logic valid;
    logic full;
  } q_stat_t;

endpackage

[hw/rtl/srp_if.sv]
// ----------------------------------------------------------------------------
// srp_in_if / srp_out_if: byte and result channels
// Valid/ready channels; a transfer happens when valid and ready are high.
// ----------------------------------------------------------------------------
interface srp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_stream;
  logic       new_session;

  modport source (output valid, output data_byte, output end_of_stream,
                  output new_session, input ready);
  modport sink   (input valid, input data_byte, input end_of_stream,
                  input new_session, output ready);
endinterface

interface srp_out_if import srp_pkg::*;;
  logic        valid;
  logic        ready;
  action_t     action;
  field_kind_t field_kind;
  logic [7:0]  field_index;
  logic [7:0]  field_byte;
  dest_kind_t  address_type;
  logic [15:0] dest_port;
  logic [7:0]  name_length;

  modport source (output valid, output action, output field_kind, output field_index,
                  output field_byte, output address_type, output dest_port,
                  output name_length, input ready);
  modport sink   (input valid, input action, input field_kind, input field_index,
                  input field_byte, input address_type, input dest_port,
                  input name_length, output ready);
endinterface

[hw/rtl/srp_front.sv]
// ----------------------------------------------------------------------------
// srp_front: byte intake and classification
// Accepts a byte while the queue has room and tags it with the protocol
// values that the parser tests against.
// ----------------------------------------------------------------------------
module srp_front import srp_pkg::*; (
  srp_in_if.sink  in_ch,
  input  q_stat_t q_stat,
  output logic    q_push,
  output q_item_t q_item
);

  assign in_ch.ready = !q_stat.full;
  assign q_push      = in_ch.valid && !q_stat.full;

  always_comb begin
    q_item.data_byte     = in_ch.data_byte;
    q_item.end_of_stream = in_ch.end_of_stream;
    q_item.new_session   = in_ch.new_session;
    q_item.is_zero       = (in_ch.data_byte == BYTE_ZERO);
    q_item.is_one        = (in_ch.data_byte == CMD_CONNECT);
    q_item.is_three      = (in_ch.data_byte == ATYP_NAME);
    q_item.is_four       = (in_ch.data_byte == VER_SOCKS4);
    q_item.is_five       = (in_ch.data_byte == VER_SOCKS5);
  end

endmodule

[hw/rtl/srp_queue.sv]
// ----------------------------------------------------------------------------
// srp_queue: short FIFO between front end and back end
// Holds classified bytes so that intake and parsing stall independently.
// ----------------------------------------------------------------------------
module srp_queue import srp_pkg::*; #(
  parameter int DEPTH = 2
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  q_item_t push_item,
  input  logic    pop,
  output q_item_t pop_item,
  output q_stat_t stat
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  q_item_t       mem [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          do_wr, do_rd;

  assign stat.valid = (count_r != '0);
  assign stat.full  = (count_r == FULL_CNT);
  assign do_wr      = push && !stat.full;
  assign do_rd      = pop && stat.valid;
  assign pop_item   = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + PW'(1);
    end
    if (do_wr && !do_rd) begin
      count_nxt = count_r + CW'(1);
    end else if (do_rd && !do_wr) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr_r] <= push_item;
    end
  end

endmodule

[hw/rtl/srp_back.sv]
// ----------------------------------------------------------------------------
// srp_back: protocol state machine and result register
// Takes one classified byte per cycle, advances the parse state and loads
// the result register; holds while a result waits to be taken.
// ----------------------------------------------------------------------------
module srp_back import srp_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  q_stat_t q_stat,
  input  q_item_t q_item,
  output logic    q_pop,
  srp_out_if.source out_ch
);

  typedef enum logic [3:0] {
    ST_VERSION = 4'd0,
    ST_S4_CMD  = 4'd1,
    ST_S4_PORT = 4'd2,
    ST_S4_ADDR = 4'd3,
    ST_S4_USER = 4'd4,
    ST_S5_MLEN = 4'd5,
    ST_S5_METH = 4'd6,
    ST_S5_CMD  = 4'd7,
    ST_S5_RSV  = 4'd8,
    ST_S5_ATYP = 4'd9,
    ST_S5_ADDR = 4'd10,
    ST_S5_NLEN = 4'd11,
    ST_S5_NAME = 4'd12,
    ST_S5_PORT = 4'd13,
    ST_DONE    = 4'd15
  } state_t;

  state_t      state_r, state_nxt, st;
  logic        auth_r, auth_nxt, auth_b;
  logic [7:0]  left_r, left_nxt, left_b, left_dec;
  logic [7:0]  pos_r, pos_nxt, pos_b, pos_inc;
  logic [15:0] port_r, port_nxt, port_b;
  logic        noauth_r, noauth_nxt, noauth_b;
  dest_kind_t  dkind_r, dkind_nxt, dkind_b;
  logic [7:0]  ncount_r, ncount_nxt, ncount_b;

  action_t     act;
  field_kind_t kind;
  logic [7:0]  idx;
  logic [7:0]  fbyte;
  logic [7:0]  b;
  logic        out_valid_r, out_valid_nxt;

  assign q_pop         = q_stat.valid && (!out_valid_r || out_ch.ready);
  assign out_valid_nxt = q_pop || (out_valid_r && !out_ch.ready);
  assign out_ch.valid  = out_valid_r;
  assign b             = q_item.data_byte;
  assign left_dec      = left_b - 8'd1;
  assign pos_inc       = pos_b + 8'd1;

  always_comb begin
    // restart the session ahead of this byte
    if (q_item.new_session) begin
      st       = ST_VERSION;
      auth_b   = 1'b0;
      left_b   = '0;
      pos_b    = '0;
      port_b   = '0;
      noauth_b = 1'b0;
      dkind_b  = DK_IPV4;
      ncount_b = '0;
    end else begin
      st       = state_r;
      auth_b   = auth_r;
      left_b   = left_r;
      pos_b    = pos_r;
      port_b   = port_r;
      noauth_b = noauth_r;
      dkind_b  = dkind_r;
      ncount_b = ncount_r;
    end

    state_nxt  = st;
    auth_nxt   = auth_b;
    left_nxt   = left_b;
    pos_nxt    = pos_b;
    port_nxt   = port_b;
    noauth_nxt = noauth_b;
    dkind_nxt  = dkind_b;
    ncount_nxt = ncount_b;
    act        = ACT_CONT;
    kind       = FK_NONE;
    idx        = '0;
    fbyte      = '0;

    if (st == ST_DONE) begin
      act = ACT_IGNORE;
    end else if (q_item.end_of_stream) begin
      act = ACT_CLOSE;
    end else begin
      case (st)
        ST_VERSION: begin
          if (q_item.is_four) begin
            state_nxt = ST_S4_CMD;
          end else if (q_item.is_five) begin
            state_nxt = auth_b ? ST_S5_CMD : ST_S5_MLEN;
          end else begin
            act = ACT_CLOSE;
          end
        end
        ST_S4_CMD: begin
          if (q_item.is_one) begin
            state_nxt = ST_S4_PORT;
            pos_nxt   = '0;
            dkind_nxt = DK_IPV4;
          end else begin
            act = ACT_CLOSE;
          end
        end
        ST_S4_PORT, ST_S5_PORT: begin
          if (pos_b == '0) begin
            kind     = FK_PORT_H;
            idx      = 8'd0;
            fbyte    = b;
            port_nxt = {b, 8'h00};
            pos_nxt  = 8'd1;
          end else begin
            kind     = FK_PORT_L;
            idx      = 8'd1;
            fbyte    = b;
            port_nxt = {port_b[15:8], b};
            if (st == ST_S4_PORT) begin
              state_nxt = ST_S4_ADDR;
              pos_nxt   = '0;
              left_nxt  = IPV4_BYTES;
            end else begin
              act = ACT_READY;
            end
          end
        end
        ST_S4_ADDR, ST_S5_ADDR: begin
          kind     = FK_ADDR;
          idx      = pos_b;
          fbyte    = b;
          pos_nxt  = pos_inc;
          left_nxt = left_dec;
          if (left_dec == '0) begin
            state_nxt = (st == ST_S4_ADDR) ? ST_S4_USER : ST_S5_PORT;
            pos_nxt   = '0;
          end
        end
        ST_S4_USER: begin
          if (q_item.is_zero) begin
            act = ACT_GRANT4;
          end else begin
            kind  = FK_USER;
            idx   = pos_b;
            fbyte = b;
            if (pos_b != POS_SAT) begin
              pos_nxt = pos_inc;
            end
          end
        end
        ST_S5_MLEN: begin
          if (q_item.is_zero) begin
            act = ACT_CLOSE;
          end else begin
            left_nxt   = b;
            pos_nxt    = '0;
            noauth_nxt = 1'b0;
            state_nxt  = ST_S5_METH;
          end
        end
        ST_S5_METH: begin
          kind       = FK_METHOD;
          idx        = pos_b;
          fbyte      = b;
          noauth_nxt = noauth_b || q_item.is_zero;
          pos_nxt    = pos_inc;
          left_nxt   = left_dec;
          if (left_dec == '0) begin
            if (noauth_nxt) begin
              act       = ACT_NOAUTH;
              auth_nxt  = 1'b1;
              state_nxt = ST_VERSION;
            end else begin
              act = ACT_CLOSE;
            end
          end
        end
        ST_S5_CMD: begin
          if (q_item.is_one) begin
            state_nxt = ST_S5_RSV;
          end else begin
            act = ACT_CLOSE;
          end
        end
        ST_S5_RSV: begin
          if (q_item.is_zero) begin
            state_nxt = ST_S5_ATYP;
          end else begin
            act = ACT_CLOSE;
          end
        end
        ST_S5_ATYP: begin
          pos_nxt = '0;
          if (q_item.is_one) begin
            dkind_nxt  = DK_IPV4;
            ncount_nxt = '0;
            left_nxt   = IPV4_BYTES;
            state_nxt  = ST_S5_ADDR;
          end else if (q_item.is_three) begin
            dkind_nxt = DK_NAME;
            state_nxt = ST_S5_NLEN;
          end else if (q_item.is_four) begin
            dkind_nxt  = DK_IPV6;
            ncount_nxt = '0;
            left_nxt   = IPV6_BYTES;
            state_nxt  = ST_S5_ADDR;
          end else begin
            act = ACT_CLOSE;
          end
        end
        ST_S5_NLEN: begin
          ncount_nxt = b;
          pos_nxt    = '0;
          if (q_item.is_zero) begin
            state_nxt = ST_S5_PORT;
          end else begin
            left_nxt  = b;
            state_nxt = ST_S5_NAME;
          end
        end
        ST_S5_NAME: begin
          kind     = FK_NAME;
          idx      = pos_b;
          fbyte    = b;
          pos_nxt  = pos_inc;
          left_nxt = left_dec;
          if (left_dec == '0) begin
            state_nxt = ST_S5_PORT;
            pos_nxt   = '0;
          end
        end
        default: begin
          act = ACT_IGNORE;
        end
      endcase
    end

    // finish the session
    if (act inside {ACT_CLOSE, ACT_GRANT4, ACT_READY, ACT_IGNORE}) begin
      state_nxt = ST_DONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_VERSION;
      auth_r      <= 1'b0;
      left_r      <= '0;
      pos_r       <= '0;
      port_r      <= '0;
      noauth_r    <= 1'b0;
      dkind_r     <= DK_IPV4;
      ncount_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (q_pop) begin
        state_r  <= state_nxt;
        auth_r   <= auth_nxt;
        left_r   <= left_nxt;
        pos_r    <= pos_nxt;
        port_r   <= port_nxt;
        noauth_r <= noauth_nxt;
        dkind_r  <= dkind_nxt;
        ncount_r <= ncount_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      out_ch.action       <= act;
      out_ch.field_kind   <= kind;
      out_ch.field_index  <= idx;
      out_ch.field_byte   <= fbyte;
      out_ch.address_type <= dkind_nxt;
      out_ch.dest_port    <= port_nxt;
      out_ch.name_length  <= ncount_nxt;
    end
  end

endmodule

[hw/rtl/socks_request_parser.sv]
// ----------------------------------------------------------------------------
// socks_request_parser: SOCKS4/SOCKS5 CONNECT request parser
// Byte-serial parser of the client side of a SOCKS handshake.
// ----------------------------------------------------------------------------
// Takes one client byte per transfer and returns exactly one result per byte,
// in order: an action (continue, SOCKS4 grant, no-auth accepted, connect
// ready, close, ignored), the captured field byte with its kind and index,
// and the running address type, destination port and name length. The block
// sustains one byte per clock cycle while the result side does not stall. A
// result is loaded into the output register at the edge at which its byte
// leaves the intake queue, which it entered at the input transfer, and can
// transfer on the next edge. The intake queue of QUEUE_DEPTH entries lets
// input transfers continue for that many bytes while results are stalled.
// Address bytes are reported in network order. After close, grant or ready
// every byte reports ignored until a byte arrives with new_session set.
module socks_request_parser import srp_pkg::*; #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic      clk,
  input  logic      rst_n,
  srp_in_if.sink    in_ch,
  srp_out_if.source out_ch
);

  q_stat_t q_stat;
  q_item_t push_item;
  q_item_t pop_item;
  logic    q_push;
  logic    q_pop;

  srp_front u_front (
    .in_ch  (in_ch),
    .q_stat (q_stat),
    .q_push (q_push),
    .q_item (push_item)
  );

  srp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (push_item),
    .pop       (q_pop),
    .pop_item  (pop_item),
    .stat      (q_stat)
  );

  srp_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_stat (q_stat),
    .q_item (pop_item),
    .q_pop  (q_pop),
    .out_ch (out_ch)
  );

endmodule

[verif/tb.sv]
// ----------------------------------------------------------------------------
// tb: testbench of the SOCKS request parser
// Drives client byte streams into the parser and checks every result against
// a predictor of the SOCKS4/SOCKS5 request grammar kept in the bench. Starts
// with directed requests, rejects and a long SOCKS4 user name, then runs
// random sessions under three idling mixes, with one long output stall.
// ----------------------------------------------------------------------------
module tb;
  import srp_pkg::*;

  typedef enum logic [3:0] {
    PS_VERSION, PS_S4_CMD, PS_S4_PORT, PS_S4_ADDR, PS_S4_USER,
    PS_S5_MLEN, PS_S5_METH, PS_S5_CMD, PS_S5_RSV, PS_S5_ATYP,
    PS_S5_ADDR, PS_S5_NLEN, PS_S5_NAME, PS_S5_PORT, PS_DONE
  } parse_phase_t;

  typedef struct packed {
    action_t     action;
    field_kind_t kind;
    logic [7:0]  index;
    logic [7:0]  fbyte;
    dest_kind_t  atype;
    logic [15:0] port;
    logic [7:0]  nlen;
  } parse_result_t;

  logic clk = 1'b0;
  logic rst_n;

  srp_in_if  in_if();
  srp_out_if out_if();

  socks_request_parser i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if)
  );

  parse_phase_t  phase;
  logic          authed;
  logic [7:0]    remaining;
  logic [7:0]    position;
  logic [15:0]   port_acc;
  logic          saw_no_auth;
  dest_kind_t    dest_form;
  logic [7:0]    declared_len;

  parse_result_t byte_outcomes[$];
  parse_result_t oldest;
  int            fail_count = 0;
  int            live_bytes = 0;
  int            sender_idle = 0;
  int            receiver_idle = 0;
  int            hold_req = 0;
  int            hold_left = 0;

  always #10 clk = ~clk;

  function automatic void clear_session();
    phase        = PS_VERSION;
    authed       = 1'b0;
    remaining    = '0;
    position     = '0;
    port_acc     = '0;
    saw_no_auth  = 1'b0;
    dest_form    = DK_IPV4;
    declared_len = '0;
  endfunction

  function automatic parse_result_t parse_client_byte(input logic [7:0] b, input logic eos,
                                                      input logic ns);
    parse_result_t r;
    if (ns)
      clear_session();
    r.action = ACT_CONT;
    r.kind   = FK_NONE;
    r.index  = '0;
    r.fbyte  = '0;
    if (phase == PS_DONE) begin
      r.action = ACT_IGNORE;
    end else if (eos) begin
      r.action = ACT_CLOSE;
    end else begin
      case (phase)
        PS_VERSION: begin
          if (b == VER_SOCKS4)
            phase = PS_S4_CMD;
          else if (b == VER_SOCKS5)
            phase = authed ? PS_S5_CMD : PS_S5_MLEN;
          else
            r.action = ACT_CLOSE;
        end
        PS_S4_CMD: begin
          if (b == CMD_CONNECT) begin
            phase     = PS_S4_PORT;
            position  = '0;
            dest_form = DK_IPV4;
          end else begin
            r.action = ACT_CLOSE;
          end
        end
        PS_S4_PORT, PS_S5_PORT: begin
          r.fbyte = b;
          if (position == 0) begin
            r.kind   = FK_PORT_H;
            port_acc = {b, 8'h00};
            position = 8'd1;
          end else begin
            r.kind        = FK_PORT_L;
            r.index       = 8'd1;
            port_acc[7:0] = b;
            if (phase == PS_S4_PORT) begin
              phase     = PS_S4_ADDR;
              position  = '0;
              remaining = IPV4_BYTES;
            end else begin
              r.action = ACT_READY;
            end
          end
        end
        PS_S4_ADDR, PS_S5_ADDR: begin
          r.kind  = FK_ADDR;
          r.index = position;
          r.fbyte = b;
          position++;
          remaining--;
          if (remaining == 0) begin
            phase    = (phase == PS_S4_ADDR) ? PS_S4_USER : PS_S5_PORT;
            position = '0;
          end
        end
        PS_S4_USER: begin
          if (b == BYTE_ZERO) begin
            r.action = ACT_GRANT4;
          end else begin
            r.kind  = FK_USER;
            r.index = position;
            r.fbyte = b;
            if (position != POS_SAT)
              position++;
          end
        end
        PS_S5_MLEN: begin
          if (b == BYTE_ZERO) begin
            r.action = ACT_CLOSE;
          end else begin
            remaining   = b;
            position    = '0;
            saw_no_auth = 1'b0;
            phase       = PS_S5_METH;
          end
        end
        PS_S5_METH: begin
          r.kind  = FK_METHOD;
          r.index = position;
          r.fbyte = b;
          if (b == BYTE_ZERO)
            saw_no_auth = 1'b1;
          position++;
          remaining--;
          if (remaining == 0) begin
            if (saw_no_auth) begin
              r.action = ACT_NOAUTH;
              authed   = 1'b1;
              phase    = PS_VERSION;
            end else begin
              r.action = ACT_CLOSE;
            end
          end
        end
        PS_S5_CMD: begin
          if (b == CMD_CONNECT)
            phase = PS_S5_RSV;
          else
            r.action = ACT_CLOSE;
        end
        PS_S5_RSV: begin
          if (b == BYTE_ZERO)
            phase = PS_S5_ATYP;
          else
            r.action = ACT_CLOSE;
        end
        PS_S5_ATYP: begin
          position = '0;
          if (b == ATYP_IPV4) begin
            dest_form    = DK_IPV4;
            declared_len = '0;
            remaining    = IPV4_BYTES;
            phase        = PS_S5_ADDR;
          end else if (b == ATYP_NAME) begin
            dest_form = DK_NAME;
            phase     = PS_S5_NLEN;
          end else if (b == ATYP_IPV6) begin
            dest_form    = DK_IPV6;
            declared_len = '0;
            remaining    = IPV6_BYTES;
            phase        = PS_S5_ADDR;
          end else begin
            r.action = ACT_CLOSE;
          end
        end
        PS_S5_NLEN: begin
          declared_len = b;
          position     = '0;
          if (b == BYTE_ZERO) begin
            phase = PS_S5_PORT;
          end else begin
            remaining = b;
            phase     = PS_S5_NAME;
          end
        end
        PS_S5_NAME: begin
          r.kind  = FK_NAME;
          r.index = position;
          r.fbyte = b;
          position++;
          remaining--;
          if (remaining == 0) begin
            phase    = PS_S5_PORT;
            position = '0;
          end
        end
        default: r.action = ACT_IGNORE;
      endcase
    end
    if (r.action inside {ACT_CLOSE, ACT_GRANT4, ACT_READY, ACT_IGNORE})
      phase = PS_DONE;
    r.atype = dest_form;
    r.port  = port_acc;
    r.nlen  = declared_len;
    return r;
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic eos, input logic ns);
    parse_result_t r;
    while ($urandom_range(99) < sender_idle) begin
      in_if.valid <= 1'b0;
      @(negedge clk);
    end
    in_if.valid         <= 1'b1;
    in_if.data_byte     <= b;
    in_if.end_of_stream <= eos;
    in_if.new_session   <= ns;
    @(posedge clk);
    while (!in_if.ready)
      @(posedge clk);
    r = parse_client_byte(b, eos, ns);
    byte_outcomes.push_back(r);
    if (r.action != ACT_IGNORE)
      live_bytes++;
    @(negedge clk);
  endtask

  // first byte opens a new session; eos_at < 0 means no end of stream
  task automatic send_session(input logic [7:0] seq[$], input int eos_at);
    for (int i = 0; i < seq.size(); i++)
      send_byte(seq[i], i == eos_at, i == 0);
  endtask

  function automatic void append_socks4(ref logic [7:0] seq[$], input int ulen);
    seq.push_back(VER_SOCKS4);
    seq.push_back(CMD_CONNECT);
    for (int i = 0; i < 6; i++)
      seq.push_back(8'($urandom_range(255)));
    for (int i = 0; i < ulen; i++)
      seq.push_back(8'($urandom_range(1, 255)));
    seq.push_back(BYTE_ZERO);
  endfunction

  task automatic check_field(input string name, input logic [15:0] want_v,
                             input logic [15:0] got_v);
    if (want_v !== got_v) begin
      $error("%s: expected %0d, got %0d", name, want_v, got_v);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) begin
      if (byte_outcomes.size() == 0) begin
        $error("result with no byte pending: action %0d", out_if.action);
        fail_count++;
      end else begin
        oldest = byte_outcomes.pop_front();
        check_field("action", 16'(oldest.action), 16'(out_if.action));
        check_field("field_kind", 16'(oldest.kind), 16'(out_if.field_kind));
        check_field("field_index", 16'(oldest.index), 16'(out_if.field_index));
        check_field("field_byte", 16'(oldest.fbyte), 16'(out_if.field_byte));
        check_field("address_type", 16'(oldest.atype), 16'(out_if.address_type));
        check_field("dest_port", oldest.port, out_if.dest_port);
        check_field("name_length", 16'(oldest.nlen), 16'(out_if.name_length));
      end
    end
  end

  always @(negedge clk) begin
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (hold_left != 0) begin
      out_if.ready <= 1'b0;
      hold_left--;
    end else begin
      out_if.ready <= ($urandom_range(99) >= receiver_idle);
    end
  end

  task automatic test_socks4_grant();
    send_session('{VER_SOCKS4, CMD_CONNECT, 8'hff, 8'h00, 8'h00, 8'hff, 8'h00, 8'hff,
                   BYTE_ZERO}, -1);
  endtask

  task automatic test_socks5_empty_name();
    send_session('{VER_SOCKS5, 8'h02, 8'hff, BYTE_ZERO, VER_SOCKS5, CMD_CONNECT, BYTE_ZERO,
                   ATYP_NAME, BYTE_ZERO, 8'h00, 8'hff}, -1);
  endtask

  task automatic test_rejects();
    send_byte(8'h07, 1'b0, 1'b1);
    send_byte(8'h00, 1'b1, 1'b0);
    send_byte(VER_SOCKS5, 1'b0, 1'b1);
    send_byte(BYTE_ZERO, 1'b0, 1'b0);
    send_byte(8'h80, 1'b1, 1'b1);
  endtask

  task automatic test_long_user_name();
    logic [7:0] seq[$];
    append_socks4(seq, 300);
    send_session(seq, -1);
  endtask

  task automatic random_session();
    logic [7:0] seq[$];
    int         pick;
    int         n;
    int         zpos;
    int         eos_at;
    int         atyp;
    int         nlen;
    pick   = $urandom_range(9);
    eos_at = -1;
    if (pick == 9) begin
      n = $urandom_range(1, 4);
      for (int i = 0; i < n; i++)
        send_byte(8'($urandom_range(255)), $urandom_range(7) == 0, 1'($urandom_range(1)));
      return;
    end
    if (pick < 3) begin
      append_socks4(seq, $urandom_range(6));
    end else begin
      seq.push_back(VER_SOCKS5);
      n = ($urandom_range(19) == 0) ? 0 : $urandom_range(1, 5);
      zpos = ($urandom_range(99) < 85 && n > 0) ? $urandom_range(n - 1) : -1;
      seq.push_back(8'(n));
      for (int i = 0; i < n; i++)
        seq.push_back((i == zpos) ? BYTE_ZERO : 8'($urandom_range(1, 255)));
      if (zpos >= 0) begin
        if ($urandom_range(9) == 0) begin
          append_socks4(seq, $urandom_range(3));
        end else begin
          seq.push_back(VER_SOCKS5);
          seq.push_back(CMD_CONNECT);
          seq.push_back(BYTE_ZERO);
          atyp = $urandom_range(2);
          if (atyp == 0) begin
            seq.push_back(ATYP_IPV4);
            for (int i = 0; i < 4; i++)
              seq.push_back(8'($urandom_range(255)));
          end else if (atyp == 1) begin
            nlen = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 12);
            seq.push_back(ATYP_NAME);
            seq.push_back(8'(nlen));
            for (int i = 0; i < nlen; i++)
              seq.push_back(8'($urandom_range(255)));
          end else begin
            seq.push_back(ATYP_IPV6);
            for (int i = 0; i < 16; i++)
              seq.push_back(8'($urandom_range(255)));
          end
          seq.push_back(8'($urandom_range(255)));
          seq.push_back(8'($urandom_range(255)));
        end
      end
    end
    if ($urandom_range(4) == 0)
      seq[$urandom_range(seq.size() - 1)] = 8'($urandom_range(255));
    if ($urandom_range(11) == 0)
      eos_at = $urandom_range(seq.size() - 1);
    repeat ($urandom_range(2))
      seq.push_back(8'($urandom_range(255)));
    send_session(seq, eos_at);
  endtask

  task automatic test_random_sessions(input int count);
    int start;
    start = live_bytes;
    while (live_bytes - start < count)
      random_session();
  endtask

  // stall the result side long enough for the intake queue to fill
  task automatic test_output_backpressure();
    hold_req = 120;
    send_session('{VER_SOCKS5, 8'h03, 8'h02, BYTE_ZERO, 8'hff, VER_SOCKS5, CMD_CONNECT,
                   BYTE_ZERO, ATYP_IPV4, 8'h0a, 8'h00, 8'h00, 8'h01, 8'h1f, 8'h90}, -1);
  endtask

  initial begin
    rst_n               = 1'b0;
    in_if.valid         = 1'b0;
    in_if.data_byte     = '0;
    in_if.end_of_stream = 1'b0;
    in_if.new_session   = 1'b0;
    out_if.ready        = 1'b0;
    clear_session();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    sender_idle   = 27;
    receiver_idle = 87;
    test_socks4_grant();
    test_socks5_empty_name();
    test_rejects();
    test_long_user_name();
    test_random_sessions(160);

    sender_idle   = 87;
    receiver_idle = 27;
    test_random_sessions(160);

    sender_idle   = 0;
    receiver_idle = 0;
    test_output_backpressure();
    test_random_sessions(160);

    in_if.valid <= 1'b0;
    while (byte_outcomes.size() != 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0)
      $display("tb passed");
    else
      $display("tb failed");
    $finish;
  end

  initial begin
    #4000000;
    $display("tb failed");
    $finish;
  end

endmodule

[filelist.f]
hw/rtl/srp_pkg.sv
hw/rtl/srp_if.sv
hw/rtl/srp_front.sv
hw/rtl/srp_queue.sv
hw/rtl/srp_back.sv
hw/rtl/socks_request_parser.sv
verif/tb.sv
